[hdl/id3v2_frame_locator_defines.svh]
`ifndef ID3V2_FRAME_LOCATOR_DEFINES_SVH
`define ID3V2_FRAME_LOCATOR_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define ID3FL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define ID3FL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/id3fl_pkg.sv]
package id3fl_pkg;

    localparam int LENGTH_BITS_DEF = 28;
    localparam int ID_BITS         = 32;
    localparam int SIZE_BITS       = 32;
    localparam int BYTE_BITS       = 8;
    localparam int CFG_DATA_BITS   = 32;
    localparam int CFG_INDEX_BITS  = 1;
    localparam int HIDX_BITS       = 4;

    localparam int HEADER_BYTES = 10;
    localparam int ID_BYTES     = 4;
    localparam int SIZE_END     = 8;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_TARGET_ID     = 1'b0,
        REG_REGION_LENGTH = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        PH_DONE    = 3'b001,
        PH_HEADER  = 3'b010,
        PH_PAYLOAD = 3'b100
    } t_phase;

endpackage

[hdl/id3fl_channels.sv]
interface id3fl_in_if;
    logic                           valid;
    logic                           ready;
    logic [id3fl_pkg::BYTE_BITS-1:0] data_byte;
    logic                           first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

interface id3fl_out_if #(parameter int LENGTH_BITS = id3fl_pkg::LENGTH_BITS_DEF);
    logic                   valid;
    logic                   ready;
    logic                   found;
    logic [LENGTH_BITS-1:0] frame_offset;
    logic [LENGTH_BITS-1:0] payload_size;

    modport source (output valid, output found, output frame_offset, output payload_size,
                    input ready);
    modport sink (input valid, input found, input frame_offset, input payload_size,
                  output ready);
endinterface

interface id3fl_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [id3fl_pkg::CFG_INDEX_BITS-1:0] index;
    logic [id3fl_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/id3v2_frame_locator.sv]
// The result is registered: it is loaded into the output register when the byte that ends the walk is accepted.
// Throughput: one byte per cycle; the input stalls only while a result sits unclaimed
// in the output register.
// Reset (synchronous, active low): walk stops and waits for a first-flagged byte with its
// counters at zero, output register empties, target ID and region length clear to zero.
module id3v2_frame_locator #(
    parameter int LENGTH_BITS = id3fl_pkg::LENGTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    id3fl_in_if.sink    i_in,
    id3fl_cfg_if.sink   i_cfg,
    id3fl_out_if.source o_out
);
    import id3fl_pkg::*;

    localparam int EndBits = ((LENGTH_BITS > SIZE_BITS) ? LENGTH_BITS : SIZE_BITS) + 2;

    // configuration
    logic [ID_BITS-1:0]     r_target;
    logic [LENGTH_BITS-1:0] r_region;

    // walk state
    t_phase                 r_phase,  n_phase;
    logic [LENGTH_BITS-1:0] r_pos,    n_pos;
    logic [HIDX_BITS-1:0]   r_hidx,   n_hidx;
    logic [ID_BITS-1:0]     r_id,     n_id;
    logic [SIZE_BITS-1:0]   r_size,   n_size;
    logic [SIZE_BITS-1:0]   r_rem,    n_rem;
    logic [LENGTH_BITS-1:0] r_start,  n_start;

    // result register
    logic                   r_out_valid, n_out_valid;
    logic                   r_found,     n_found;
    logic [LENGTH_BITS-1:0] r_offset,    n_offset;
    logic [LENGTH_BITS-1:0] r_psize,     n_psize;

    logic                   in_accept;
    logic                   emit;
    logic                   first;
    t_phase                 c_phase;
    logic [LENGTH_BITS-1:0] c_pos;
    logic [HIDX_BITS-1:0]   c_hidx;
    logic [ID_BITS-1:0]     c_id;
    logic [SIZE_BITS-1:0]   c_size;
    logic [SIZE_BITS-1:0]   c_rem;
    logic [LENGTH_BITS-1:0] c_start;
    logic [LENGTH_BITS:0]   pos_inc;
    logic [EndBits-1:0]     frame_end;
    logic [SIZE_BITS-1:0]   rem_dec;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_accept   = i_in.valid && i_in.ready;

    assign o_out.valid        = r_out_valid;
    assign o_out.found        = r_found;
    assign o_out.frame_offset = r_offset;
    assign o_out.payload_size = r_psize;

    // A first-flagged byte restarts the walk from a clean header state.
    assign first   = i_in.first_byte;
    assign c_phase = first ? PH_HEADER : r_phase;
    assign c_pos   = first ? '0 : r_pos;
    assign c_hidx  = first ? '0 : r_hidx;
    assign c_id    = first ? '0 : r_id;
    assign c_size  = first ? '0 : r_size;
    assign c_rem   = first ? '0 : r_rem;
    assign c_start = first ? '0 : r_start;

    assign pos_inc   = {1'b0, c_pos} + (LENGTH_BITS+1)'(1);
    assign frame_end = EndBits'(c_start) + EndBits'(HEADER_BYTES) + EndBits'(c_size);
    assign rem_dec   = c_rem - SIZE_BITS'(1);

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_hidx   = r_hidx;
        n_id     = r_id;
        n_size   = r_size;
        n_rem    = r_rem;
        n_start  = r_start;
        emit     = 1'b0;
        n_found  = 1'b0;
        n_offset = '0;
        n_psize  = '0;

        if (in_accept) begin
            n_phase = c_phase;
            n_pos   = c_pos;
            n_hidx  = c_hidx;
            n_id    = c_id;
            n_size  = c_size;
            n_rem   = c_rem;
            n_start = c_start;

            if (first && r_region == '0) begin
                emit = 1'b1;
            end else begin
                unique case (c_phase)
                    PH_DONE: begin
                        // ignore until the next first-flagged byte
                    end
                    PH_HEADER: begin
                        if (c_hidx < HIDX_BITS'(ID_BYTES)) begin
                            n_id = {c_id[ID_BITS-BYTE_BITS-1:0], i_in.data_byte};
                        end else if (c_hidx < HIDX_BITS'(SIZE_END)) begin
                            n_size = {c_size[SIZE_BITS-BYTE_BITS-1:0], i_in.data_byte};
                        end
                        n_hidx = c_hidx + HIDX_BITS'(1);
                        if (c_hidx == HIDX_BITS'(HEADER_BYTES - 1)) begin
                            n_hidx = '0;
                            if (c_size == '0 || frame_end > EndBits'(r_region)) begin
                                emit = 1'b1;
                            end else if (c_id == r_target) begin
                                emit     = 1'b1;
                                n_found  = 1'b1;
                                n_offset = c_start;
                                n_psize  = c_size[LENGTH_BITS-1:0];
                            end else begin
                                n_rem   = c_size;
                                n_phase = PH_PAYLOAD;
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        n_rem = rem_dec;
                        if (rem_dec == '0) begin
                            n_phase = PH_HEADER;
                            n_hidx  = '0;
                            n_id    = '0;
                            n_size  = '0;
                            n_start = pos_inc[LENGTH_BITS-1:0];
                        end
                    end
                    default: begin
                        n_phase = PH_DONE;
                    end
                endcase

                if (c_phase != PH_DONE && !emit) begin
                    if (pos_inc >= {1'b0, r_region}) begin
                        emit = 1'b1;
                    end else begin
                        n_pos = pos_inc[LENGTH_BITS-1:0];
                    end
                end
            end

            if (emit) begin
                n_phase = PH_DONE;
            end
        end

        if (in_accept && emit) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_DONE;
            r_out_valid <= 1'b0;
            r_target    <= '0;
            r_region    <= '0;
        end else begin
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (t_cfg_reg'(i_cfg.index))
                    REG_TARGET_ID:     r_target <= i_cfg.data[ID_BITS-1:0];
                    REG_REGION_LENGTH: r_region <= i_cfg.data[LENGTH_BITS-1:0];
                    default:           r_target <= r_target;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_hidx   <= '0;
            r_id     <= '0;
            r_size   <= '0;
            r_rem    <= '0;
            r_start  <= '0;
            r_found  <= 1'b0;
            r_offset <= '0;
            r_psize  <= '0;
        end else begin
            r_pos   <= n_pos;
            r_hidx  <= n_hidx;
            r_id    <= n_id;
            r_size  <= n_size;
            r_rem   <= n_rem;
            r_start <= n_start;
            if (in_accept && emit) begin
                r_found  <= n_found;
                r_offset <= n_offset;
                r_psize  <= n_psize;
            end
        end
    end

endmodule

[hdl/id3fl_checker.sv]
`include "id3v2_frame_locator_defines.svh"

module id3fl_checker #(
    parameter int LENGTH_BITS = id3fl_pkg::LENGTH_BITS_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic                   i_found,
    input logic [LENGTH_BITS-1:0] i_frame_offset,
    input logic [LENGTH_BITS-1:0] i_payload_size
);

    logic hit_shown;
    logic miss_shown;
    logic miss_clear;
    logic out_idle;
    logic out_stalled;

    assign hit_shown   = i_out_valid && i_found;
    assign miss_shown  = i_out_valid && !i_found;
    assign miss_clear  = (i_frame_offset == '0) && (i_payload_size == '0);
    assign out_idle    = !i_out_valid && !(i_in_valid && i_in_ready);
    assign out_stalled = i_out_valid && !i_out_ready;

    // A located frame always carries a nonzero payload.
    `ID3FL_ASSERT_NOW(a_found_size, hit_shown, i_payload_size != '0, "found with zero size")

    // Not-found results carry zero offset and size.
    `ID3FL_ASSERT_NOW(a_miss_zero, miss_shown, miss_clear, "not-found with nonzero fields")

    // A new result appears only after a request was taken.
    `ID3FL_ASSERT_NEXT(a_result_cause, out_idle, !i_out_valid, "result without request")

    // Input stays open whenever the output register is empty.
    `ID3FL_ASSERT_NOW(a_ready_open, !i_out_valid, i_in_ready, "input stalled with empty output")

    // Hold a stalled result until the receiver takes it.
    `ID3FL_ASSERT_NEXT(a_out_hold, out_stalled, i_out_valid && $stable(i_found), "result lost")

endmodule

bind id3v2_frame_locator id3fl_checker #(.LENGTH_BITS(LENGTH_BITS)) u_id3fl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_found        (o_out.found),
    .i_frame_offset (o_out.frame_offset),
    .i_payload_size (o_out.payload_size)
);

[tb/sv/tb_id3v2_frame_locator.sv]
module tb_id3v2_frame_locator;
    import id3fl_pkg::*;

    localparam int LB            = LENGTH_BITS_DEF;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int LONG_HOLD     = 80;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic          found;
        logic [LB-1:0] offset;
        logic [LB-1:0] size;
    } t_locate;

    logic i_clk = 1'b0;
    logic i_rst_n;

    id3fl_in_if                     in_ch ();
    id3fl_cfg_if                    cfg_ch ();
    id3fl_out_if #(.LENGTH_BITS(LB)) out_ch ();

    id3v2_frame_locator #(.LENGTH_BITS(LB)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // Walk state mirrored from the block
    logic [ID_BITS-1:0]   target_cfg;
    logic [LB-1:0]        region_cfg;
    logic [LB-1:0]        walk_pos;
    logic [LB-1:0]        frame_base;
    t_phase               walk_ph;
    int                   hdr_idx;
    logic [ID_BITS-1:0]   id_acc;
    logic [SIZE_BITS-1:0] size_acc;
    logic [SIZE_BITS-1:0] pay_left;

    t_locate    pending_locates[$];
    logic [7:0] tag_q[$];

    int  err_count    = 0;
    int  items_fed    = 0;
    int  results_seen = 0;
    int  hits_seen    = 0;
    int  cfg_writes   = 0;
    int  cycle_count  = 0;
    int  gap_odds     = 0;
    bit  long_hold_req = 1'b0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("tb_id3v2_frame_locator: mismatch on %s: got 0x%0h, want 0x%0h",
                 what, got, want);
        err_count++;
    endtask

    function automatic void clear_walk();
        target_cfg = '0;
        region_cfg = '0;
        walk_pos   = '0;
        frame_base = '0;
        walk_ph    = PH_DONE;
        hdr_idx    = 0;
        id_acc     = '0;
        size_acc   = '0;
        pay_left   = '0;
    endfunction

    function automatic void post_locate(logic hit, logic [LB-1:0] off, logic [LB-1:0] sz);
        t_locate r;
        r.found  = hit;
        r.offset = off;
        r.size   = sz;
        pending_locates.push_back(r);
        walk_ph = PH_DONE;
    endfunction

    // Advance the walk by one accepted byte; returns 0 when the byte is dropped.
    function automatic bit walk_step(logic [7:0] b, logic f);
        longint frame_end;
        if (f) begin
            walk_pos   = '0;
            frame_base = '0;
            hdr_idx    = 0;
            id_acc     = '0;
            size_acc   = '0;
            pay_left   = '0;
            walk_ph    = PH_HEADER;
            if (region_cfg == '0) begin
                post_locate(1'b0, '0, '0);
                return 1'b1;
            end
        end
        if (walk_ph == PH_DONE)
            return 1'b0;
        if (walk_ph == PH_HEADER) begin
            if (hdr_idx < ID_BYTES)
                id_acc = {id_acc[ID_BITS-9:0], b};
            else if (hdr_idx < SIZE_END)
                size_acc = {size_acc[SIZE_BITS-9:0], b};
            hdr_idx++;
            if (hdr_idx >= HEADER_BYTES) begin
                hdr_idx = 0;
                frame_end = longint'(frame_base) + longint'(HEADER_BYTES)
                            + longint'(size_acc);
                if (size_acc == '0 || frame_end > longint'(region_cfg)) begin
                    post_locate(1'b0, '0, '0);
                    return 1'b1;
                end
                if (id_acc == target_cfg) begin
                    post_locate(1'b1, frame_base, size_acc[LB-1:0]);
                    return 1'b1;
                end
                pay_left = size_acc;
                walk_ph  = PH_PAYLOAD;
            end
        end else begin
            pay_left--;
            if (pay_left == '0) begin
                walk_ph    = PH_HEADER;
                hdr_idx    = 0;
                id_acc     = '0;
                size_acc   = '0;
                frame_base = walk_pos + LB'(1);
            end
        end
        if (longint'(walk_pos) + longint'(1) >= longint'(region_cfg)) begin
            post_locate(1'b0, '0, '0);
            return 1'b1;
        end
        walk_pos = walk_pos + LB'(1);
        return 1'b1;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic f);
        bit took;
        if (gap_odds != 0 && $urandom_range(1, 100) <= gap_odds) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= b;
        in_ch.first_byte <= f;
        do begin
            @(negedge i_clk);
            took = in_ch.ready;
            @(posedge i_clk);
        end while (!took);
        if (walk_step(b, f))
            items_fed++;
    endtask

    task automatic program_regs(input bit set_tgt, input logic [ID_BITS-1:0] tgt,
                                input bit set_len, input int unsigned len);
        t_cfg_reg                 idx;
        logic [CFG_DATA_BITS-1:0] val;
        bit                       took;
        for (int i = 0; i < 2; i++) begin
            if ((i == 0) ? set_tgt : set_len) begin
                idx = (i == 0) ? REG_TARGET_ID : REG_REGION_LENGTH;
                val = (idx == REG_TARGET_ID) ? tgt : CFG_DATA_BITS'(len);
                cfg_ch.valid <= 1'b1;
                cfg_ch.index <= idx;
                cfg_ch.data  <= val;
                do begin
                    @(negedge i_clk);
                    took = cfg_ch.ready;
                    @(posedge i_clk);
                end while (!took);
                if (idx == REG_TARGET_ID)
                    target_cfg = val;
                else
                    region_cfg = val[LB-1:0];
                cfg_writes++;
            end
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Drop valid and wait until every pending result is out and the block is quiet.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending_locates.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] id_char();
        return ($urandom_range(0, 4) == 0) ? 8'($urandom_range(48, 57))
                                           : 8'($urandom_range(65, 90));
    endfunction

    function automatic logic [ID_BITS-1:0] fresh_target();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom;
            default: return {id_char(), id_char(), id_char(), id_char()};
        endcase
    endfunction

    function automatic logic [ID_BITS-1:0] pick_id(logic [ID_BITS-1:0] tgt);
        logic [ID_BITS-1:0] id;
        int                 lane;
        id = tgt;
        case ($urandom_range(0, 3))
            0: id = tgt;
            1: begin
                lane = $urandom_range(0, 3);
                id[8*lane +: 8] = id[8*lane +: 8] ^ 8'($urandom_range(1, 255));
            end
            2:       id = {id_char(), id_char(), id_char(), id_char()};
            default: id = $urandom;
        endcase
        return id;
    endfunction

    function automatic void add_frame(logic [ID_BITS-1:0] id, logic [SIZE_BITS-1:0] size,
                                      int body);
        for (int k = 3; k >= 0; k--)
            tag_q.push_back(id[8*k +: 8]);
        for (int k = 3; k >= 0; k--)
            tag_q.push_back(size[8*k +: 8]);
        repeat (2) tag_q.push_back(8'($urandom));
        repeat (body) tag_q.push_back(8'($urandom));
    endfunction

    // Build one frame area with random content, program the region and walk it.
    task automatic walk_one_tag(input bit with_gaps);
        logic [ID_BITS-1:0] tgt;
        bit                 new_tgt;
        int                 kind, sz, len, span, stop_at, shrink_at, n_send;
        tgt     = target_cfg;
        new_tgt = ($urandom_range(0, 2) == 0);
        if (new_tgt)
            tgt = fresh_target();
        tag_q.delete();
        repeat ($urandom_range(1, 5)) begin
            kind = $urandom_range(0, 19);
            if (kind == 0) begin
                add_frame(pick_id(tgt), '0, 0);
            end else if (kind == 1) begin
                add_frame(pick_id(tgt), $urandom, 0);
            end else begin
                sz = $urandom_range(1, (kind == 2) ? 64 : 10);
                add_frame(pick_id(tgt), sz, sz);
            end
        end
        len = tag_q.size();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: span = len;
            5: begin
                span = len + $urandom_range(1, 12);
                while (tag_q.size() < span) tag_q.push_back(8'h00);
            end
            6: span = $urandom_range(1, len);
            7: span = len - 1;
            8: begin
                span = len + $urandom_range(4, 20);
                while (tag_q.size() < span) tag_q.push_back(8'($urandom));
            end
            default: span = $urandom_range(len, 28'hFFFFFFF);
        endcase
        settle();
        gap_odds = (with_gaps && $urandom_range(0, 3) != 0) ? 20 : 0;
        program_regs(new_tgt, tgt, 1'b1, span);
        stop_at   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len) : len;
        shrink_at = (stop_at > 2 && $urandom_range(0, 14) == 0)
                    ? $urandom_range(1, stop_at - 1) : -1;
        n_send    = (stop_at < len) ? stop_at : tag_q.size();
        for (int i = 0; i < n_send; i++) begin
            if (i == shrink_at) begin
                settle();
                program_regs(1'b0, '0, 1'b1, $urandom_range(0, i + 2));
            end
            push_byte(tag_q[i], i == 0);
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0);
    endtask

    task automatic scatter_noise();
        repeat ($urandom_range(3, 20))
            push_byte(8'($urandom), $urandom_range(0, 5) == 0);
    endtask

    task automatic test_empty_region();
        settle();
        gap_odds = 20;
        program_regs(1'b1, 32'h54495432, 1'b1, '0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b0);
    endtask

    task automatic test_header_cut();
        settle();
        program_regs(1'b0, '0, 1'b1, 3);
        push_byte(8'h54, 1'b1);
        push_byte(8'h49, 1'b0);
        push_byte(8'h54, 1'b0);
    endtask

    // Padding header whose ID also matches: the zero size wins.
    task automatic test_padding_frame();
        settle();
        program_regs(1'b1, '1, 1'b1, '1);
        for (int i = 0; i < HEADER_BYTES; i++)
            push_byte((i < ID_BYTES || i >= SIZE_END) ? 8'hFF : 8'h00, i == 0);
    endtask

    // Frame that ends exactly at the region end.
    task automatic test_exact_fit();
        settle();
        program_regs(1'b1, '0, 1'b1, 12);
        for (int i = 0; i < HEADER_BYTES; i++)
            push_byte((i == SIZE_END - 1) ? 8'h02 : 8'h00, i == 0);
    endtask

    task automatic test_region_shrink();
        settle();
        program_regs(1'b1, 32'h54414C42, 1'b1, 40);
        push_byte(8'h54, 1'b1);
        push_byte(8'h41, 1'b0);
        push_byte(8'h4C, 1'b0);
        push_byte(8'h42, 1'b0);
        settle();
        program_regs(1'b0, '0, 1'b1, 2);
        push_byte(8'h00, 1'b0);
    endtask

    // Hold the receiver off while first bytes keep coming, so the input stalls.
    task automatic test_output_backpressure();
        settle();
        gap_odds = 0;
        program_regs(1'b0, '0, 1'b1, '0);
        long_hold_req = 1'b1;
        repeat (24) push_byte(8'($urandom), 1'b1);
        settle();
    endtask

    task automatic test_random_walks();
        while (items_fed < 1500 || results_seen < 40) begin
            if ($urandom_range(0, 9) == 0)
                scatter_noise();
            else
                walk_one_tag(1'b1);
        end
    endtask

    task automatic test_quiet_walks();
        settle();
        gap_odds = 0;
        while (items_fed < 1700)
            walk_one_tag(1'b0);
    endtask

    // Receiver: random short stalls, plus one long hold on request
    initial begin
        int hold;
        hold = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end else if (hold == 0 && gap_odds != 0 && $urandom_range(1, 100) <= gap_odds) begin
                hold = $urandom_range(1, 3);
            end
            if (hold > 0) begin
                out_ch.ready <= 1'b0;
                hold--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Signals are stable between edges; a handshake seen here completes at the next rise.
    always @(negedge i_clk) begin
        t_locate want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            results_seen++;
            if (pending_locates.size() == 0) begin
                report_mismatch("result with none pending", 32'(out_ch.found), 0);
            end else begin
                want = pending_locates.pop_front();
                if (want.found)
                    hits_seen++;
                if (out_ch.found !== want.found)
                    report_mismatch("found", 32'(out_ch.found), 32'(want.found));
                if (out_ch.frame_offset !== want.offset)
                    report_mismatch("frame_offset", 32'(out_ch.frame_offset),
                                    32'(want.offset));
                if (out_ch.payload_size !== want.size)
                    report_mismatch("payload_size", 32'(out_ch.payload_size),
                                    32'(want.size));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_id3v2_frame_locator: timeout after %0d cycles", cycle_count);
            $display("tb_id3v2_frame_locator: done, errors");
            $finish;
        end
    end

    initial begin
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.data_byte  <= '0;
        in_ch.first_byte <= 1'b0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= REG_TARGET_ID;
        cfg_ch.data      <= '0;
        clear_walk();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_region();
        test_header_cut();
        test_padding_frame();
        test_exact_fit();
        test_region_shrink();
        test_output_backpressure();
        test_random_walks();
        test_quiet_walks();

        in_ch.valid <= 1'b0;
        for (int n = 0; n < 1000 && pending_locates.size() != 0; n++)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_locates.size() != 0)
            report_mismatch("results never returned", pending_locates.size(), 0);

        $display("tb_id3v2_frame_locator: %0d bytes walked, %0d results (%0d frames located),",
                 items_fed, results_seen, hits_seen);
        $display("tb_id3v2_frame_locator: %0d register writes, %0d mismatches",
                 cfg_writes, err_count);
        if (err_count == 0)
            $display("tb_id3v2_frame_locator: done, clean");
        else
            $display("tb_id3v2_frame_locator: done, errors");
        $finish;
    end

endmodule
